### design/trs_pkg.sv
// Shared types, constants and pixel packing functions for the textured
// span rasterizer. No dependencies.
package trs_pkg;

  localparam int TEX_DEPTH_DEF = 16384;
  localparam int MAX_SPAN      = 64;

  localparam int IDX_W   = 14;
  localparam int LEN_W   = 7;
  localparam int TEXEL_W = 16;
  localparam int ACC_W   = 64;
  localparam int CFG_W   = 14;
  localparam int CFG_A_W = 2;
  localparam int MODE_W  = 2;
  localparam int IN_TDATA_W  = 296;
  localparam int OUT_TDATA_W = 16;

  localparam logic [3:0] ALPHA_OPAQUE = 4'hF;

  typedef enum logic [0:0] {
    FUNC_TEXEL_WR = 1'b0,
    FUNC_SPAN     = 1'b1
  } func_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_SPAN_MODE = 2'd0,
    REG_X_MASK    = 2'd1,
    REG_Y_MASK    = 2'd2
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_COLOR    = 2'd0,
    MODE_TEXTURE  = 2'd1,
    MODE_MODULATE = 2'd2
  } span_mode_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SPAN = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load_span;
    logic load_texel;
    logic issue;
    logic last;
  } dp_cmd_t;

  function automatic logic [15:0] pack_opaque(input logic [63:0] c);
    pack_opaque = {1'b0, c[47:43], c[31:27], c[15:11]};
  endfunction

  function automatic logic [15:0] pack_alpha(input logic [63:0] c);
    if (c[63:60] == ALPHA_OPAQUE) begin
      pack_alpha = pack_opaque(c);
    end else begin
      pack_alpha = {1'b1, c[47:44], c[63], c[31:28], c[62], c[15:12], c[61]};
    end
  endfunction

  function automatic logic [63:0] unpack_texel(input logic [15:0] t);
    logic [15:0] a;
    a = t[15] ? {t[10], t[5], t[0], 13'd0} : 16'hFFFF;
    unpack_texel = {a, t[14:10], 11'd0, t[9:5], 11'd0, t[4:0], 11'd0};
  endfunction

endpackage

### design/trs_ctrl.sv
// Controller: takes requests, counts the pixels of a span and issues
// commands to the datapath. Depends on trs_pkg.
module trs_ctrl import trs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  func_t            req_func,
  input  logic [LEN_W-1:0] req_len,
  input  logic             pipe_adv,
  output logic             req_ready,
  output dp_cmd_t          cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_sat;
  logic             accept;

  assign len_sat = (32'(req_len) > MAX_SPAN) ? LEN_W'(MAX_SPAN) : req_len;
  assign req_ready = (state_r == ST_IDLE) && pipe_adv;
  assign accept = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_func == FUNC_SPAN) begin
            cmd.load_span = 1'b1;
            cnt_nxt       = len_sat;
            if (len_sat != '0) begin
              state_nxt = ST_SPAN;
            end
          end else begin
            cmd.load_texel = 1'b1;
          end
        end
      end
      ST_SPAN: begin
        if (pipe_adv) begin
          cmd.issue = 1'b1;
          cmd.last  = (cnt_r == LEN_W'(1));
          cnt_nxt   = cnt_r - LEN_W'(1);
          if (cnt_r == LEN_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/trs_datapath.sv
// Datapath: configuration registers, accumulators, texel index wrap,
// texel memory, lane modulation and the output register. Depends on trs_pkg.
module trs_datapath import trs_pkg::*; #(
  parameter int TEX_DEPTH = TEX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  dp_cmd_t            cmd,
  input  logic [IDX_W-1:0]   texel_addr,
  input  logic [TEXEL_W-1:0] texel_value,
  input  logic [ACC_W-1:0]   color_start,
  input  logic [ACC_W-1:0]   color_step,
  input  logic [ACC_W-1:0]   tex_start,
  input  logic [ACC_W-1:0]   tex_step,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [TEXEL_W-1:0] out_pixel,
  output logic               out_last,
  output logic               pipe_adv
);

  localparam int ADDR_W  = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
  localparam int DEP_W   = 21;
  localparam int SHIFT   = 28;
  localparam int RECIP_W = 25;
  localparam int PROD_W  = IDX_W + RECIP_W;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam int QD_W    = Q_W + DEP_W;
  localparam int unsigned RECIP = (32'd1 << SHIFT) / TEX_DEPTH;
  localparam logic [DEP_W-1:0] DEPTH_C = DEP_W'(TEX_DEPTH);

  logic [MODE_W-1:0] mode_r;
  logic [CFG_W-1:0]  x_mask_r, y_mask_r;

  logic [ACC_W-1:0] color_acc_r, tex_acc_r, color_step_r, tex_step_r;
  logic [IDX_W-1:0] raw_idx;

  logic               s1_v_r, s1_wr_r, s1_last_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [ACC_W-1:0]   s1_color_r;
  logic [PROD_W-1:0]  s1_prod;

  logic               s2_v_r, s2_wr_r, s2_last_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic [ACC_W-1:0]   s2_color_r;
  logic [Q_W-1:0]     s2_q_r;
  logic [QD_W-1:0]    s2_qd;

  logic               s3_v_r, s3_wr_r, s3_last_r;
  logic [IDX_W-1:0]   s3_idx_r;
  logic [ACC_W-1:0]   s3_color_r;
  logic [IDX_W-1:0]   s3_qd_r;
  logic [IDX_W-1:0]   s3_rem;
  logic [DEP_W-1:0]   s3_rem_ext, s3_wrap;
  logic [ADDR_W-1:0]  s3_addr;

  logic [TEXEL_W-1:0] mem [TEX_DEPTH];

  logic               s4_v_r, s4_last_r;
  logic [TEXEL_W-1:0] s4_texel_r;
  logic [ACC_W-1:0]   s4_color_r;
  logic [ACC_W-1:0]   s4_unpacked;
  logic [31:0]        s4_lane [4];
  logic [ACC_W-1:0]   s4_prod;

  logic               s5_v_r, s5_last_r;
  logic [TEXEL_W-1:0] s5_texel_r;
  logic [ACC_W-1:0]   s5_color_r, s5_mod_r;
  logic [TEXEL_W-1:0] s5_pixel;

  logic               out_valid_r, out_last_r;
  logic [TEXEL_W-1:0] out_pixel_r;

  assign pipe_adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      x_mask_r <= '0;
      y_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SPAN_MODE: mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_X_MASK:    x_mask_r <= cfg_wdata;
        REG_Y_MASK:    y_mask_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_acc_r  <= '0;
      tex_acc_r    <= '0;
      color_step_r <= '0;
      tex_step_r   <= '0;
    end else if (cmd.load_span) begin
      color_acc_r  <= color_start;
      tex_acc_r    <= tex_start;
      color_step_r <= color_step;
      tex_step_r   <= tex_step;
    end else if (cmd.issue) begin
      color_acc_r <= color_acc_r + color_step_r;
      tex_acc_r   <= tex_acc_r + tex_step_r;
    end
  end

  assign raw_idx = (tex_acc_r[45:32] & y_mask_r) | (tex_acc_r[29:16] & x_mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_adv) begin
      s1_v_r <= cmd.issue || cmd.load_texel;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r && !s3_wr_r;
      s5_v_r <= s4_v_r;
      out_valid_r <= s5_v_r;
    end
  end

  assign s1_prod = PROD_W'(s1_idx_r) * PROD_W'(RECIP);
  assign s2_qd   = QD_W'(s2_q_r) * QD_W'(DEPTH_C);
  assign s3_rem  = s3_idx_r - s3_qd_r;
  assign s3_rem_ext = DEP_W'(s3_rem);
  assign s3_wrap = (s3_rem_ext >= DEPTH_C) ? (s3_rem_ext - DEPTH_C) : s3_rem_ext;
  assign s3_addr = s3_wrap[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      s1_wr_r    <= cmd.load_texel;
      s1_last_r  <= cmd.last;
      s1_idx_r   <= cmd.load_texel ? texel_addr : raw_idx;
      s1_color_r <= cmd.load_texel ? ACC_W'(texel_value) : color_acc_r;

      s2_wr_r    <= s1_wr_r;
      s2_last_r  <= s1_last_r;
      s2_idx_r   <= s1_idx_r;
      s2_color_r <= s1_color_r;
      s2_q_r     <= s1_prod[PROD_W-1:SHIFT];

      s3_wr_r    <= s2_wr_r;
      s3_last_r  <= s2_last_r;
      s3_idx_r   <= s2_idx_r;
      s3_color_r <= s2_color_r;
      s3_qd_r    <= s2_qd[IDX_W-1:0];

      s4_last_r  <= s3_last_r;
      s4_color_r <= s3_color_r;

      s5_last_r  <= s4_last_r;
      s5_texel_r <= s4_texel_r;
      s5_color_r <= s4_color_r;
      s5_mod_r   <= s4_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv && s3_v_r) begin
      if (s3_wr_r) begin
        mem[s3_addr] <= s3_color_r[TEXEL_W-1:0];
      end else begin
        s4_texel_r <= mem[s3_addr];
      end
    end
  end

  assign s4_unpacked = unpack_texel(s4_texel_r);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s4_lane[k] = 32'(s4_unpacked[16*k +: 16]) * 32'(s4_color_r[16*k +: 16]);
      s4_prod[16*k +: 16] = s4_lane[k][31:16];
    end
  end

  always_comb begin
    case (span_mode_t'(mode_r))
      MODE_TEXTURE:  s5_pixel = s5_texel_r;
      MODE_MODULATE: s5_pixel = pack_alpha(s5_mod_r);
      default:       s5_pixel = pack_opaque(s5_color_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe_adv && s5_v_r) begin
      out_pixel_r <= s5_pixel;
      out_last_r  <= s5_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

### design/textured_span_rasterizer_core.sv
// Top level of the textured span rasterizer: stream ports, controller and
// datapath. Depends on trs_pkg, trs_ctrl and trs_datapath.
//
// A texel-write request (in_tuser 0) gives no pixel. A span request
// (in_tuser 1) is taken, then its pixels enter the pixel pipeline one per
// cycle while the output is not stalled; a span of N pixels (N saturated to
// 64) holds the input until its last pixel has entered, and the next request
// can be taken after that. On its way out each pixel passes index masking,
// two stages of address wrap to the texel memory depth, the registered texel
// memory read, the lane multiply and the output register.
// A stalled output holds the whole pipeline. The texel memory is one port,
// shared in order by writes and reads, and needs no clearing after reset.
module textured_span_rasterizer_core import trs_pkg::*; #(
  parameter int TEX_DEPTH = TEX_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // texel_addr, texel_value, color_start, color_step, tex_start, tex_step,
  // span_len, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pixel
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  dp_cmd_t cmd;
  logic    pipe_adv;

  trs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_func  (func_t'(in_tuser)),
    .req_len   (in_tdata[292:286]),
    .pipe_adv  (pipe_adv),
    .req_ready (in_tready),
    .cmd       (cmd)
  );

  trs_datapath #(
    .TEX_DEPTH (TEX_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .texel_addr  (in_tdata[13:0]),
    .texel_value (in_tdata[29:14]),
    .color_start (in_tdata[93:30]),
    .color_step  (in_tdata[157:94]),
    .tex_start   (in_tdata[221:158]),
    .tex_step    (in_tdata[285:222]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_pixel   (out_tdata),
    .out_last    (out_tlast),
    .pipe_adv    (pipe_adv)
  );

endmodule

### test/textured_span_rasterizer_core_tb.sv
// Testbench for textured_span_rasterizer_core: a directed table and random
// phases in every span mode, with a pixel predictor and a scoreboard.
// Depends on trs_pkg and the core RTL.
module textured_span_rasterizer_core_tb;
  import trs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RAND_ITEMS     = 105;
  localparam int RAND_PHASES    = 7;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DIR_ROWS       = 21;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CFG_W-1:0]   xm;
    logic [CFG_W-1:0]   ym;
    func_t              func;
    logic [IDX_W-1:0]   addr;
    logic [TEXEL_W-1:0] val;
    logic [ACC_W-1:0]   cs;
    logic [ACC_W-1:0]   cst;
    logic [ACC_W-1:0]   ts;
    logic [ACC_W-1:0]   tst;
    logic [LEN_W-1:0]   len;
    logic               typed;
    logic [TEXEL_W-1:0] exp_pix;
  } row_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] pix;
    logic               last;
  } pixel_t;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam row_t PLAN [DIR_ROWS] = '{
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_SPAN, 14'h0, 16'h0, 64'h0, 64'h0, 64'h0, 64'h0,
      7'd1, 1'b1, 16'h0000},
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_SPAN, 14'h0, 16'h0, ONES, 64'h0, 64'h0, 64'h0,
      7'd1, 1'b1, 16'h7FFF},
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_SPAN, 14'h0, 16'h0, 64'h1234_5678_9ABC_DEF0,
      64'h0000_0800_0800_0800, 64'h0, 64'h0, 7'd0, 1'b0, 16'h0},
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_SPAN, 14'h0, 16'h0, 64'h0,
      64'h0001_0400_0400_0400, 64'h0, 64'h0, 7'd127, 1'b0, 16'h0},
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_SPAN, 14'h0, 16'h0, ONES, ONES, ONES, ONES,
      7'd64, 1'b0, 16'h0},
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_TEXEL_WR, 14'h0000, 16'hFFFF, 64'h0, 64'h0,
      64'h0, 64'h0, 7'd0, 1'b0, 16'h0},
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_TEXEL_WR, 14'h3FFF, 16'h8421, 64'h0, 64'h0,
      64'h0, 64'h0, 7'd0, 1'b0, 16'h0},
    '{MODE_COLOR, 14'h0, 14'h0, FUNC_TEXEL_WR, 14'h0001, 16'h7FFF, 64'h0, 64'h0,
      64'h0, 64'h0, 7'd0, 1'b0, 16'h0},
    '{MODE_SPARE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, ONES, 64'h0, 64'h0,
      64'h0, 7'd1, 1'b1, 16'h7FFF},
    '{MODE_TEXTURE, 14'h0, 14'h0, FUNC_SPAN, 14'h0, 16'h0, 64'h0, 64'h0, ONES, 64'h0,
      7'd1, 1'b1, 16'hFFFF},
    '{MODE_TEXTURE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, 64'h0, 64'h0,
      64'h0000_0000_3FFF_0000, 64'h0, 7'd1, 1'b1, 16'h8421},
    '{MODE_TEXTURE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, 64'h0, 64'h0,
      64'h0000_3FFF_0000_0000, 64'h0, 7'd1, 1'b1, 16'h8421},
    '{MODE_TEXTURE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, 64'h0, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 7'd20, 1'b0, 16'h0},
    '{MODE_TEXTURE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, 64'h0, 64'h0,
      64'h0000_0007_0009_0000, 64'h0, 7'd0, 1'b0, 16'h0},
    '{MODE_MODULATE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, 64'h0, 64'h0,
      64'h0000_0000_0001_0000, 64'h0, 7'd1, 1'b1, 16'h8000},
    '{MODE_MODULATE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, ONES, 64'h0,
      64'h0000_0000_0001_0000, 64'h0, 7'd1, 1'b0, 16'h0},
    '{MODE_MODULATE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0, ONES, 64'h0,
      64'h0, 64'h0, 7'd1, 1'b0, 16'h0},
    '{MODE_MODULATE, 14'h3FFF, 14'h3FFF, FUNC_SPAN, 14'h0, 16'h0,
      64'h8F3C_72A1_5D0E_E4B7, 64'hF01D_0333_0A5F_FEED, 64'h0000_0005_0003_0000,
      64'h0000_0001_0001_0000, 7'd16, 1'b0, 16'h0},
    '{MODE_MODULATE, 14'h00FF, 14'h3F00, FUNC_SPAN, 14'h0, 16'h0,
      64'h3C5A_9E01_77D2_0BF8, 64'h0123_4567_89AB_CDEF, 64'hDEAD_BEEF_CAFE_F00D,
      64'h0105_0203_0307_1111, 7'd64, 1'b0, 16'h0},
    '{MODE_MODULATE, 14'h00FF, 14'h3F00, FUNC_TEXEL_WR, 14'h2AAA, 16'h5555, 64'h0,
      64'h0, 64'h0, 64'h0, 7'd0, 1'b0, 16'h0},
    '{MODE_MODULATE, 14'h00FF, 14'h3F00, FUNC_TEXEL_WR, 14'h1555, 16'hAAAA, 64'h0,
      64'h0, 64'h0, 64'h0, 7'd0, 1'b0, 16'h0}
  };

  localparam logic [MODE_W-1:0] PHASE_MODE [RAND_PHASES] = '{
    MODE_MODULATE, MODE_TEXTURE, MODE_COLOR, MODE_MODULATE, MODE_SPARE,
    MODE_TEXTURE, MODE_MODULATE
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_A_W-1:0]     cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  textured_span_rasterizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  logic [TEXEL_W-1:0] texel_mem [TEX_DEPTH_DEF];
  bit                 texel_seen [TEX_DEPTH_DEF];
  logic [MODE_W-1:0]  mode_now;
  logic [CFG_W-1:0]   xmask_now;
  logic [CFG_W-1:0]   ymask_now;
  pixel_t             pending_pixels [$];
  pixel_t             oldest;
  int                 fails;
  int                 reqs_sent;
  int                 tx_idle_pct;
  int                 rx_idle_pct = 53;
  logic               hold_req = 1'b0;
  logic               hold_ack = 1'b0;
  int                 hold_left = 0;
  int                 idle_cnt;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [15:0] rgb555_plain(input logic [63:0] c);
    return 16'(((c >> 33) & 64'h7C00) | ((c >> 22) & 64'h03E0) | ((c >> 11) & 64'h001F));
  endfunction

  function automatic logic [15:0] rgb555_keyed(input logic [63:0] c);
    logic [3:0]  nib;
    logic [15:0] p;
    nib = c[63:60];
    if (nib == 4'hF) begin
      p = rgb555_plain(c);
    end else begin
      p = 16'(((c >> 33) & 64'h7800) | ((c >> 22) & 64'h03C0) | ((c >> 11) & 64'h001E));
      p = p | 16'h8000;
      if (nib[3]) p = p | 16'h0400;
      if (nib[2]) p = p | 16'h0020;
      if (nib[1]) p = p | 16'h0001;
    end
    return p;
  endfunction

  function automatic logic [63:0] texel_lanes(input logic [15:0] t);
    logic [15:0] alpha;
    alpha = t[15] ? {t[10], t[5], t[0], 13'b0} : 16'hFFFF;
    return {alpha, t[14:10], 11'b0, t[9:5], 11'b0, t[4:0], 11'b0};
  endfunction

  function automatic logic [63:0] lanes_scale(input logic [63:0] x, input logic [63:0] y);
    logic [31:0] prod;
    logic [63:0] res;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      prod = 32'(x[16*k +: 16]) * 32'(y[16*k +: 16]);
      res[16*k +: 16] = prod[31:16];
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] texel_index(input logic [63:0] pos);
    return IDX_W'(((pos >> 32) & 64'(ymask_now)) | ((pos >> 16) & 64'(xmask_now)));
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_request(
    input logic [IDX_W-1:0] addr, input logic [TEXEL_W-1:0] val,
    input logic [63:0] cs, input logic [63:0] cst, input logic [63:0] ts,
    input logic [63:0] tst, input logic [LEN_W-1:0] len);
    return {3'b0, len, tst, ts, cst, cs, val, addr};
  endfunction

  function automatic void predict_pixels(
    input func_t f, input logic [IDX_W-1:0] addr, input logic [TEXEL_W-1:0] val,
    input logic [63:0] cs, input logic [63:0] cst, input logic [63:0] ts,
    input logic [63:0] tst, input logic [LEN_W-1:0] len, input bit keep);
    logic [63:0] color;
    logic [63:0] pos;
    logic [15:0] texel;
    int          n;
    pixel_t      e;
    if (f == FUNC_TEXEL_WR) begin
      texel_mem[addr] = val;
      texel_seen[addr] = 1'b1;
    end else begin
      color = cs;
      pos = ts;
      n = (len > MAX_SPAN) ? MAX_SPAN : int'(len);
      for (int i = 0; i < n; i++) begin
        texel = texel_mem[texel_index(pos)];
        if (mode_now == MODE_TEXTURE) begin
          e.pix = texel;
        end else if (mode_now == MODE_MODULATE) begin
          e.pix = rgb555_keyed(lanes_scale(texel_lanes(texel), color));
        end else begin
          e.pix = rgb555_plain(color);
        end
        e.last = (i == n - 1);
        if (keep) pending_pixels.push_back(e);
        color = color + cst;
        pos = pos + tst;
      end
    end
  endfunction

  task automatic offer(input func_t f, input logic [IN_TDATA_W-1:0] d);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    reqs_sent++;
  endtask

  task automatic store_texel(input logic [IDX_W-1:0] addr, input logic [TEXEL_W-1:0] val);
    predict_pixels(FUNC_TEXEL_WR, addr, val, '0, '0, '0, '0, '0, 1'b1);
    offer(FUNC_TEXEL_WR, pack_request(addr, val, '0, '0, '0, '0, '0));
  endtask

  // in texture or modulate mode, write every texel that the span will read and that holds nothing yet
  task automatic fill_texels(input logic [63:0] ts, input logic [63:0] tst,
                             input logic [LEN_W-1:0] len);
    logic [63:0]      pos;
    logic [IDX_W-1:0] idx;
    int               n;
    pos = ts;
    n = (len > MAX_SPAN) ? MAX_SPAN : int'(len);
    if (mode_now == MODE_TEXTURE || mode_now == MODE_MODULATE) begin
      for (int i = 0; i < n; i++) begin
        idx = texel_index(pos);
        if (!texel_seen[idx]) store_texel(idx, 16'($urandom));
        pos = pos + tst;
      end
    end
  endtask

  task automatic draw_span(input logic [63:0] cs, input logic [63:0] cst,
                           input logic [63:0] ts, input logic [63:0] tst,
                           input logic [LEN_W-1:0] len, input bit typed,
                           input logic [TEXEL_W-1:0] exp_pix);
    fill_texels(ts, tst, len);
    predict_pixels(FUNC_SPAN, '0, '0, cs, cst, ts, tst, len, !typed);
    if (typed) pending_pixels.push_back('{pix: exp_pix, last: 1'b1});
    offer(FUNC_SPAN, pack_request('0, '0, cs, cst, ts, tst, len));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [MODE_W-1:0] m, input logic [CFG_W-1:0] xm,
                            input logic [CFG_W-1:0] ym);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SPAN_MODE;
    cfg_wdata <= CFG_W'(m);
    @(posedge clk);
    cfg_addr  <= REG_X_MASK;
    cfg_wdata <= xm;
    @(posedge clk);
    cfg_addr  <= REG_Y_MASK;
    cfg_wdata <= ym;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_now  = m;
    xmask_now = xm;
    ymask_now = ym;
    @(posedge clk);
  endtask

  task automatic random_request();
    logic [63:0]      tst;
    logic [LEN_W-1:0] len;
    int               r;
    if ($urandom_range(99) < 25) begin
      store_texel(IDX_W'($urandom_range(16383)), 16'($urandom_range(65535)));
    end else begin
      r = $urandom_range(99);
      if (r < 5) len = 7'd0;
      else if (r < 10) len = 7'd64;
      else if (r < 14) len = 7'($urandom_range(127, 65));
      else len = 7'($urandom_range(12, 1));
      if ($urandom_range(1)) begin
        tst = {32'($urandom_range(2)), 16'($urandom_range(3)), 16'($urandom)};
      end else begin
        tst = {$urandom, $urandom};
      end
      draw_span({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, tst,
                len, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: actual pixel=%h last=%b", $time, out_tdata,
                 out_tlast);
        fails++;
      end else begin
        oldest = pending_pixels.pop_front();
        if (out_tdata !== oldest.pix) begin
          $display("%0t: pixel mismatch: expected %h actual %h", $time, oldest.pix,
                   out_tdata);
          fails++;
        end
        if (out_tlast !== oldest.last) begin
          $display("%0t: last mismatch: expected %b actual %b", $time, oldest.last,
                   out_tlast);
          fails++;
        end
      end
    end
  end

  initial begin
    idle_cnt = 0;
    while (idle_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t r;
    int   mark;
    logic [CFG_W-1:0] xm;
    logic [CFG_W-1:0] ym;
    fails       = 0;
    reqs_sent   = 0;
    tx_idle_pct = 19;
    mode_now    = MODE_COLOR;
    xmask_now   = '0;
    ymask_now   = '0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_SPAN_MODE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_TEXEL_WR;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      r = PLAN[i];
      if (r.mode != mode_now || r.xm != xmask_now || r.ym != ymask_now) begin
        settle();
        write_regs(r.mode, r.xm, r.ym);
      end
      if (r.func == FUNC_TEXEL_WR) begin
        store_texel(r.addr, r.val);
      end else begin
        draw_span(r.cs, r.cst, r.ts, r.tst, r.len, r.typed, r.exp_pix);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin
          xm = 14'h3FFF;
          ym = 14'h3FFF;
        end
        1: begin
          xm = 14'h0;
          ym = 14'h0;
        end
        2: begin
          xm = CFG_W'($urandom);
          ym = CFG_W'($urandom);
        end
        default: begin
          xm = CFG_W'((1 << $urandom_range(8, 1)) - 1);
          ym = CFG_W'((1 << $urandom_range(8, 1)) - 1);
        end
      endcase
      write_regs(PHASE_MODE[ph], xm, ym);
      if (ph < 3) begin
        tx_idle_pct = 19;
        rx_idle_pct <= 53;
      end else if (ph < 5) begin
        tx_idle_pct = 53;
        rx_idle_pct <= 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (ph == 3) hold_req <= ~hold_req;
      mark = reqs_sent;
      while (reqs_sent - mark < RAND_ITEMS / RAND_PHASES) random_request();
    end

    settle();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
design/trs_pkg.sv
design/trs_ctrl.sv
design/trs_datapath.sv
design/textured_span_rasterizer_core.sv
test/textured_span_rasterizer_core_tb.sv
